// ----- sv/fdc_pkg.sv -----
// Shared constants and tables for the fisheye dewarp coordinate generator.
// Used by the top level, the CORDIC pipeline and the port checker.
`default_nettype none

package fdc_pkg;

   localparam int MAX_DIAMETER = 4096;
   localparam int FRAC_BITS    = 4;

   // Field widths fixed by the interface
   localparam int COORD_W   = 12;
   localparam int CSR_W     = 13;
   localparam int FOV_W     = 9;
   localparam int OUT_W     = 19;
   localparam int CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIAMETER = 1'b0,
      CSR_FOV      = 1'b1
   } csr_index_type;

   // Clamped diameter width
   localparam int D_W = $clog2(MAX_DIAMETER + 1);

   // Binary angles: 2^32 is one full turn
   localparam int ANG_W = 32;
   localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;
   localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;

   localparam int CORDIC_STEPS = 28;
   localparam int XY_W = 34;
   localparam int Z_W  = 34;
   localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;

   localparam logic [ANG_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5};

   // Pixel-to-angle divider: dividend is coordinate * 2^32
   localparam int DIV1_STEPS = COORD_W + 32;
   localparam int DIV1_Q_W   = 33;

   // Radius: D*360*p, then divided by fov * 2^16
   localparam int D360_W = D_W + 9;
   localparam int NUM_W  = D360_W + ANG_W;
   localparam int R_W    = NUM_W - 16;

   localparam int SIDE_W = (R_W > XY_W) ? R_W : XY_W;

   localparam logic signed [OUT_W-1:0] OUT_HI = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_LO = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

`default_nettype wire

// ----- sv/fdc_cordic.sv -----
// Fully pipelined CORDIC, one iteration per register stage.
// Rotation mode gives cos/sin of a binary angle; vectoring mode gives angle and
// gain-scaled length. Depends on fdc_pkg.
`default_nettype none

module fdc_cordic import fdc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    vec_mode,
   input  logic                    in_valid,
   input  logic signed [XY_W-1:0]  in_x,
   input  logic signed [XY_W-1:0]  in_y,
   input  logic [ANG_W-1:0]        in_ang,
   input  logic [SIDE_W-1:0]       in_side,
   output logic                    out_valid,
   output logic signed [XY_W-1:0]  out_x,
   output logic signed [XY_W-1:0]  out_y,
   output logic [ANG_W-1:0]        out_ang,
   output logic [SIDE_W-1:0]       out_side
);

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   flip;
      logic [SIDE_W-1:0]      side;
   } cstage_type;

   cstage_type st_ff [CORDIC_STEPS];
   cstage_type st_in [CORDIC_STEPS];
   cstage_type start;
   cstage_type last;
   logic       val_ff [CORDIC_STEPS];
   logic       neg;
   logic       rflip;

   function automatic cstage_type cordic_step(cstage_type s, int i, logic vmode);
      cstage_type r;
      logic       dir;
      r   = s;
      // vectoring drives y to zero, rotation drives z to zero
      dir = vmode ? s.y[XY_W-1] : ~s.z[Z_W-1];
      if (dir) begin
         r.x = s.x - (s.y >>> i);
         r.y = s.y + (s.x >>> i);
         r.z = s.z - $signed(Z_W'(ATAN_TURNS[i]));
      end else begin
         r.x = s.x + (s.y >>> i);
         r.y = s.y - (s.x >>> i);
         r.z = s.z + $signed(Z_W'(ATAN_TURNS[i]));
      end
      return r;
   endfunction

   // Range reduction into the right half plane
   always_comb begin
      neg   = in_x[XY_W-1];
      rflip = in_ang[ANG_W-1] ^ in_ang[ANG_W-2];
      start.side = in_side;
      if (vec_mode) begin
         start.x    = neg ? -in_x : in_x;
         start.y    = neg ? -in_y : in_y;
         start.z    = neg ? $signed(Z_W'(HALF_TURN)) : '0;
         start.flip = 1'b0;
      end else begin
         start.x    = $signed(XY_W'(INV_GAIN_Q30));
         start.y    = '0;
         start.z    = $signed({{(Z_W-ANG_W+1){in_ang[ANG_W-1] ^ rflip}},
                              in_ang[ANG_W-2:0]});
         start.flip = rflip;
      end
   end

   always_comb begin
      st_in[0] = cordic_step(start, 0, vec_mode);
      for (int k = 1; k < CORDIC_STEPS; k++) begin
         st_in[k] = cordic_step(st_ff[k-1], k, vec_mode);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CORDIC_STEPS; k++) begin
            val_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         val_ff[0] <= in_valid;
         for (int k = 1; k < CORDIC_STEPS; k++) begin
            val_ff[k] <= val_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < CORDIC_STEPS; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign last      = st_ff[CORDIC_STEPS-1];
   assign out_valid = val_ff[CORDIC_STEPS-1];
   assign out_x     = last.flip ? -last.x : last.x;
   assign out_y     = last.flip ? -last.y : last.y;
   assign out_ang   = last.z[ANG_W-1:0];
   assign out_side  = last.side;

endmodule

`default_nettype wire

// ----- sv/fisheye_dewarp_coordinate_generator.sv -----
// Fisheye dewarp coordinate generator: maps an equirectangular pixel to a
// fisheye source coordinate. Depends on fdc_pkg and fdc_cordic.
//
// Usage:
//  - req channel carries (column, row); rsp channel returns source_x,
//    source_y (signed, FRAC_BITS fraction bits) and clipped, one rsp per req.
//  - csr port writes diameter (index 0) and fov_degrees (index 1); write only
//    while the pipeline is empty.
//  - Throughput: one request per clock while rsp_stall holds no waiting result.
//    The path is 44 divider stages, three 28-stage CORDIC levels plus one more for
//    the azimuth, a 38-stage radius divider and five multiply/output stages.
//    The pipeline depth is set by the unrolled dividers and the CORDICs.
//  - When rsp_stall holds a waiting result, the whole pipeline freezes and
//    req_stall rises the same cycle; nothing is dropped or repeated.
//  - Reset clears all valid bits and restores diameter 1024 and fov 180.
//  - Out of range coordinates saturate and set clipped.
`default_nettype none

module fisheye_dewarp_coordinate_generator import fdc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [COORD_W-1:0]        req_column,
   input  logic [COORD_W-1:0]        req_row,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [OUT_W-1:0]   rsp_source_x,
   output logic signed [OUT_W-1:0]   rsp_source_y,
   output logic                      rsp_clipped,
   input  logic                      csr_write,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_W-1:0]          csr_data
);

   localparam int PX_W  = R_W + 1 + (XY_W - 10);
   localparam int SUM_W = PX_W + 1;
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(OUT_HI);
   localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(OUT_LO);

   typedef struct packed {
      logic [D_W-1:0]      rem;
      logic [COORD_W-1:0]  dvd;
      logic [DIV1_Q_W-1:0] q;
   } div1_type;

   typedef struct packed {
      logic [FOV_W-1:0] rem;
      logic [R_W-1:0]   dvd;
      logic [R_W-1:0]   q;
      logic [ANG_W-1:0] az;
   } div2_type;

   function automatic logic [D_W-1:0] clamp_diam(logic [CSR_W-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      if (w == 32'd0) begin
         return D_W'(1);
      end else if (w > 32'(MAX_DIAMETER)) begin
         return D_W'(MAX_DIAMETER);
      end
      return D_W'(v);
   endfunction

   function automatic div1_type div1_step(div1_type s, logic [D_W-1:0] d);
      div1_type     r;
      logic [D_W:0] t;
      logic         ge;
      t     = {s.rem, s.dvd[COORD_W-1]};
      ge    = t >= {1'b0, d};
      r.rem = ge ? D_W'(t - {1'b0, d}) : D_W'(t);
      r.dvd = s.dvd << 1;
      r.q   = {s.q[DIV1_Q_W-2:0], ge};
      return r;
   endfunction

   function automatic div2_type div2_step(div2_type s, logic [FOV_W-1:0] f);
      div2_type       r;
      logic [FOV_W:0] t;
      logic           ge;
      t     = {s.rem, s.dvd[R_W-1]};
      ge    = t >= {1'b0, f};
      r.rem = ge ? FOV_W'(t - {1'b0, f}) : FOV_W'(t);
      r.dvd = s.dvd << 1;
      r.q   = {s.q[R_W-2:0], ge};
      r.az  = s.az;
      return r;
   endfunction

   // round half up to FRAC_BITS, then saturate; bit OUT_W is the clip flag
   function automatic logic [OUT_W:0] finish(logic signed [SUM_W-1:0] sum);
      logic signed [SUM_W-1:0] v;
      v = (sum + (SUM_W'(1) << (35 - FRAC_BITS))) >>> (36 - FRAC_BITS);
      if (v > SAT_HI) begin
         return {1'b1, OUT_HI};
      end else if (v < SAT_LO) begin
         return {1'b1, OUT_LO};
      end
      return {1'b0, v[OUT_W-1:0]};
   endfunction

   // ---------------- configuration ----------------
   logic [D_W-1:0]   diam_ff;
   logic [FOV_W-1:0] fov_ff;
   logic [D360_W-1:0] d360;

   always_ff @(posedge clock) begin
      if (reset) begin
         diam_ff <= clamp_diam(CSR_W'(1024));
         fov_ff  <= FOV_W'(180);
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_DIAMETER: diam_ff <= clamp_diam(csr_data);
            CSR_FOV: begin
               fov_ff <= (csr_data[FOV_W-1:0] == '0) ? FOV_W'(1) : csr_data[FOV_W-1:0];
            end
            default: ;
         endcase
      end
   end

   assign d360 = D360_W'(diam_ff) * D360_W'(360);

   // ---------------- flow control ----------------
   logic advance;
   logic rsp_valid_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // ---------------- pixel to angle dividers ----------------
   div1_type col_ff [DIV1_STEPS];
   div1_type col_in [DIV1_STEPS];
   div1_type row_ff [DIV1_STEPS];
   div1_type row_in [DIV1_STEPS];
   logic     dv1_ff [DIV1_STEPS];

   always_comb begin
      col_in[0] = div1_step('{rem: '0, dvd: req_column, q: '0}, diam_ff);
      row_in[0] = div1_step('{rem: '0, dvd: req_row, q: '0}, diam_ff);
      for (int k = 1; k < DIV1_STEPS; k++) begin
         col_in[k] = div1_step(col_ff[k-1], diam_ff);
         row_in[k] = div1_step(row_ff[k-1], diam_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV1_STEPS; k++) begin
            dv1_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         dv1_ff[0] <= req_valid;
         for (int k = 1; k < DIV1_STEPS; k++) begin
            dv1_ff[k] <= dv1_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < DIV1_STEPS; k++) begin
            col_ff[k] <= col_in[k];
            row_ff[k] <= row_in[k];
         end
      end
   end

   logic [ANG_W-1:0] lon;
   logic [ANG_W-1:0] lat;
   logic [DIV1_Q_W-1:0] col_q;
   logic [DIV1_Q_W-1:0] row_q;

   assign col_q = col_ff[DIV1_STEPS-1].q;
   assign row_q = row_ff[DIV1_STEPS-1].q;
   assign lon   = {~col_q[ANG_W-1], col_q[ANG_W-2:0]};
   assign lat   = row_q[ANG_W:1] - QUARTER_TURN;

   // ---------------- sin/cos of longitude and latitude ----------------
   logic                   sc_valid;
   logic signed [XY_W-1:0] lon_c;
   logic signed [XY_W-1:0] lon_s;
   logic signed [XY_W-1:0] lat_c;
   logic signed [XY_W-1:0] lat_s;

   fdc_cordic u_lon (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .vec_mode (1'b0),
      .in_valid (dv1_ff[DIV1_STEPS-1]),
      .in_x     ('0),
      .in_y     ('0),
      .in_ang   (lon),
      .in_side  ('0),
      .out_valid(sc_valid),
      .out_x    (lon_c),
      .out_y    (lon_s),
      .out_ang  (),
      .out_side ()
   );

   fdc_cordic u_lat (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .vec_mode (1'b0),
      .in_valid (dv1_ff[DIV1_STEPS-1]),
      .in_x     ('0),
      .in_y     ('0),
      .in_ang   (lat),
      .in_side  ('0),
      .out_valid(),
      .out_x    (lat_c),
      .out_y    (lat_s),
      .out_ang  (),
      .out_side ()
   );

   // ---------------- point on the sphere ----------------
   logic                   sph_valid_ff;
   logic signed [XY_W-1:0] px_in;
   logic signed [XY_W-1:0] py_in;
   logic signed [XY_W-1:0] sx_ff;
   logic signed [XY_W-1:0] sy_ff;
   logic signed [XY_W-1:0] sz_ff;
   logic signed [63:0]     prod_x;
   logic signed [63:0]     prod_y;

   assign prod_x = $signed(lat_c[31:0]) * $signed(lon_s[31:0]);
   assign prod_y = $signed(lat_c[31:0]) * $signed(lon_c[31:0]);
   assign px_in  = prod_x[30+XY_W-1:30];
   assign py_in  = prod_y[30+XY_W-1:30];

   always_ff @(posedge clock) begin
      if (reset) begin
         sph_valid_ff <= 1'b0;
      end else if (advance) begin
         sph_valid_ff <= sc_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sx_ff <= px_in;
         sy_ff <= py_in;
         sz_ff <= lat_s;
      end
   end

   // ---------------- azimuth and length of (x, z) ----------------
   logic                   v1_valid;
   logic signed [XY_W-1:0] magk;
   logic [ANG_W-1:0]       az1;
   logic [SIDE_W-1:0]      v1_side;

   fdc_cordic u_vec_az (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .vec_mode (1'b1),
      .in_valid (sph_valid_ff),
      .in_x     (sx_ff),
      .in_y     (sz_ff),
      .in_ang   ('0),
      .in_side  (SIDE_W'($unsigned(sy_ff))),
      .out_valid(v1_valid),
      .out_x    (magk),
      .out_y    (),
      .out_ang  (az1),
      .out_side (v1_side)
   );

   // remove CORDIC gain from the length
   logic                          gain_valid_ff;
   logic signed [XY_W+32-1:0]     prod_m;
   logic signed [XY_W-1:0]        m_ff;
   logic signed [XY_W-1:0]        yv_ff;
   logic [ANG_W-1:0]              az_e_ff;

   assign prod_m = magk * $signed({1'b0, INV_GAIN_Q30[30:0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_valid_ff <= 1'b0;
      end else if (advance) begin
         gain_valid_ff <= v1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_ff    <= prod_m[30+XY_W-1:30];
         yv_ff   <= $signed(v1_side[XY_W-1:0]);
         az_e_ff <= az1;
      end
   end

   // ---------------- polar angle ----------------
   logic              v2_valid;
   logic [ANG_W-1:0]  pol;
   logic [SIDE_W-1:0] v2_side;

   fdc_cordic u_vec_pol (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .vec_mode (1'b1),
      .in_valid (gain_valid_ff),
      .in_x     (yv_ff),
      .in_y     (m_ff),
      .in_ang   ('0),
      .in_side  (SIDE_W'(az_e_ff)),
      .out_valid(v2_valid),
      .out_x    (),
      .out_y    (),
      .out_ang  (pol),
      .out_side (v2_side)
   );

   // clamp to zero..half turn, then scale by D*360
   logic [ANG_W-1:0] pol_clamp;
   logic             num_valid_ff;
   logic [NUM_W-1:0] num_ff;
   logic [ANG_W-1:0] az_g_ff;

   assign pol_clamp = (pol[ANG_W-1] && pol != HALF_TURN) ? '0 : pol;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_valid_ff <= 1'b0;
      end else if (advance) begin
         num_valid_ff <= v2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff  <= NUM_W'(d360) * NUM_W'(pol_clamp);
         az_g_ff <= v2_side[ANG_W-1:0];
      end
   end

   // ---------------- radius divider (by fov) ----------------
   div2_type rad_ff [R_W];
   div2_type rad_in [R_W];
   logic     dv2_ff [R_W];

   always_comb begin
      rad_in[0] = div2_step('{rem: '0, dvd: num_ff[NUM_W-1:16], q: '0, az: az_g_ff},
                            fov_ff);
      for (int k = 1; k < R_W; k++) begin
         rad_in[k] = div2_step(rad_ff[k-1], fov_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < R_W; k++) begin
            dv2_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         dv2_ff[0] <= num_valid_ff;
         for (int k = 1; k < R_W; k++) begin
            dv2_ff[k] <= dv2_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < R_W; k++) begin
            rad_ff[k] <= rad_in[k];
         end
      end
   end

   // ---------------- cos/sin of azimuth ----------------
   logic                   az_valid;
   logic signed [XY_W-1:0] caz;
   logic signed [XY_W-1:0] saz;
   logic [SIDE_W-1:0]      r_side;

   fdc_cordic u_az (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .vec_mode (1'b0),
      .in_valid (dv2_ff[R_W-1]),
      .in_x     ('0),
      .in_y     ('0),
      .in_ang   (rad_ff[R_W-1].az),
      .in_side  (SIDE_W'(rad_ff[R_W-1].q)),
      .out_valid(az_valid),
      .out_x    (caz),
      .out_y    (saz),
      .out_ang  (),
      .out_side (r_side)
   );

   // ---------------- radius times direction ----------------
   logic                   off_valid_ff;
   logic signed [PX_W-1:0] offx_ff;
   logic signed [PX_W-1:0] offy_ff;
   logic signed [R_W:0]    r16s;

   assign r16s = $signed({1'b0, r_side[R_W-1:0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         off_valid_ff <= 1'b0;
      end else if (advance) begin
         off_valid_ff <= az_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         offx_ff <= r16s * $signed(caz[XY_W-1:10]);
         offy_ff <= r16s * $signed(saz[XY_W-1:10]);
      end
   end

   // ---------------- centre, rounding, saturation ----------------
   logic signed [SUM_W-1:0] centre;
   logic [OUT_W:0]          fin_x;
   logic [OUT_W:0]          fin_y;
   logic signed [OUT_W-1:0] rsp_x_ff;
   logic signed [OUT_W-1:0] rsp_y_ff;
   logic                    rsp_clip_ff;

   assign centre = $signed(SUM_W'({diam_ff, 35'b0}));
   assign fin_x  = finish(centre + SUM_W'(offx_ff));
   assign fin_y  = finish(centre + SUM_W'(offy_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= off_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_x_ff    <= $signed(fin_x[OUT_W-1:0]);
         rsp_y_ff    <= $signed(fin_y[OUT_W-1:0]);
         rsp_clip_ff <= fin_x[OUT_W] | fin_y[OUT_W];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_source_x = rsp_x_ff;
   assign rsp_source_y = rsp_y_ff;
   assign rsp_clipped  = rsp_clip_ff;

endmodule

`default_nettype wire

// ----- sv/fdc_checker.sv -----
// Port-level checks for the fisheye dewarp coordinate generator, bound to the
// top level. Depends on fdc_pkg.
`default_nettype none

module fdc_checker import fdc_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic [COORD_W-1:0]      req_column,
   input logic [COORD_W-1:0]      req_row,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [OUT_W-1:0] rsp_source_x,
   input logic signed [OUT_W-1:0] rsp_source_y,
   input logic                    rsp_clipped,
   input logic                    csr_write,
   input logic [CSR_IDX_W-1:0]    csr_index,
   input logic [CSR_W-1:0]        csr_data
);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_source_x)
         && $stable(rsp_source_y) && $stable(rsp_clipped))
      else $error("rsp payload changed while stalled");

   // the pipeline only backs up when a finished result is held
   a_req_stall: assert property (@(posedge clock)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a held result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // clipping always lands on a range limit
   a_clip_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |-> rsp_source_x == OUT_HI || rsp_source_x == OUT_LO
         || rsp_source_y == OUT_HI || rsp_source_y == OUT_LO)
      else $error("clipped set on an unsaturated result");

endmodule

bind fisheye_dewarp_coordinate_generator fdc_checker u_fdc_checker (.*);

`default_nettype wire
